// ===== rtl/core/mwsm_pkg.sv =====
`default_nettype none
package mwsm_pkg;

	// fixed-point formats
	localparam int TRIG_FRAC = 30;
	localparam int TRIG_W = 32;
	localparam int MAG_W = 17;
	localparam int SP_W = 50;
	localparam int ABS_W = SP_W - 1;
	localparam int ANG_W = 9;
	localparam int IDX_W = 7;
	localparam int Q_W = 7;
	localparam int PCT_W = 8;
	localparam int PCT_SCALE = 100;
	localparam int NUM_WHEELS = 4;

	// angle constants in degrees
	localparam logic [ANG_W:0] ANG_OFFSET = 10'd45;
	localparam logic [ANG_W:0] ANG_QUARTER = 10'd90;
	localparam logic [ANG_W:0] ANG_HALF = 10'd180;
	localparam logic [ANG_W:0] ANG_THREE_Q = 10'd270;
	localparam logic [ANG_W:0] ANG_FULL = 10'd360;

	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam longint unsigned SQRT2_Q30 = 64'd1518500250;
	localparam longint unsigned HALF_Q30 = 64'd536870912;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	// sine of 0..90 degrees in Q2.30 by an eight-term series
	function automatic longint unsigned unit_sine(input int unsigned deg);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		x = (64'(deg) * PI_Q30 + 64'd90) / 64'd180;
		x2 = (x * x + HALF_Q30) >> TRIG_FRAC;
		term = x;
		sum = longint'(x);
		term = ((term * x2) >> TRIG_FRAC) / 64'd6;
		sum = sum - longint'(term);
		term = ((term * x2) >> TRIG_FRAC) / 64'd20;
		sum = sum + longint'(term);
		term = ((term * x2) >> TRIG_FRAC) / 64'd42;
		sum = sum - longint'(term);
		term = ((term * x2) >> TRIG_FRAC) / 64'd72;
		sum = sum + longint'(term);
		term = ((term * x2) >> TRIG_FRAC) / 64'd110;
		sum = sum - longint'(term);
		term = ((term * x2) >> TRIG_FRAC) / 64'd156;
		sum = sum + longint'(term);
		term = ((term * x2) >> TRIG_FRAC) / 64'd210;
		sum = sum - longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > longint'(ONE_Q30)) begin
			sum = longint'(ONE_Q30);
		end
		return longint'(sum);
	endfunction

	// sqrt(2) * sin for 0..90 degrees, rounded half up
	function automatic logic [90:0][TRIG_W-1:0] build_sin_tbl();
		logic [90:0][TRIG_W-1:0] t;
		longint unsigned s;
		for (int k = 0; k <= 90; k++) begin
			s = unit_sine(k);
			t[k] = TRIG_W'((s * SQRT2_Q30 + HALF_Q30) >> TRIG_FRAC);
		end
		return t;
	endfunction

	localparam logic [90:0][TRIG_W-1:0] SIN_TBL = build_sin_tbl();

	// sqrt(2) * sin of an angle in 0..359 degrees, signed Q2.30
	function automatic logic signed [TRIG_W-1:0] scaled_sine(input logic [ANG_W-1:0] ang);
		logic [ANG_W:0] a;
		logic [1:0] quad;
		logic [ANG_W:0] r;
		logic [IDX_W-1:0] idx;
		logic [TRIG_W-1:0] mag;
		a = {1'b0, ang};
		if (a >= ANG_THREE_Q) begin
			quad = 2'd3;
			r = a - ANG_THREE_Q;
		end else if (a >= ANG_HALF) begin
			quad = 2'd2;
			r = a - ANG_HALF;
		end else if (a >= ANG_QUARTER) begin
			quad = 2'd1;
			r = a - ANG_QUARTER;
		end else begin
			quad = 2'd0;
			r = a;
		end
		idx = quad[0] ? IDX_W'(ANG_QUARTER - r) : IDX_W'(r);
		mag = SIN_TBL[idx];
		return quad[1] ? -$signed(mag) : $signed(mag);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mwsm_trig.sv =====
`default_nettype none
module mwsm_trig #(
	parameter int FRAC_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [15:0] magnitude,
	input  logic [8:0] heading_deg,
	input  logic signed [15:0] rotation,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [mwsm_pkg::TRIG_W-1:0] sc_s1,
	output logic signed [mwsm_pkg::TRIG_W-1:0] cc_s1,
	output logic signed [mwsm_pkg::MAG_W-1:0] mag_s1,
	output logic signed [15:0] rot_s1
);
	import mwsm_pkg::*;

	localparam logic signed [32:0] MAG_ONE = 33'sd1 <<< FRAC_BITS;

	logic v_s1;
	logic adv1;
	logic signed [32:0] mag_ext;
	logic signed [32:0] mag_clamp;
	logic [ANG_W:0] a_sum;
	logic [ANG_W-1:0] ang;
	logic [ANG_W:0] c_sum;
	logic [ANG_W-1:0] cang;

	// clamp magnitude to +-1.0
	always_comb begin
		mag_ext = 33'(magnitude);
		if (mag_ext > MAG_ONE) begin
			mag_clamp = MAG_ONE;
		end else if (mag_ext < -MAG_ONE) begin
			mag_clamp = -MAG_ONE;
		end else begin
			mag_clamp = mag_ext;
		end
	end

	// heading + 45 and the cosine angle, both mod 360
	always_comb begin
		a_sum = {1'b0, heading_deg} + ANG_OFFSET;
		ang = (a_sum >= ANG_FULL) ? ANG_W'(a_sum - ANG_FULL) : ANG_W'(a_sum);
		c_sum = {1'b0, ang} + ANG_QUARTER;
		cang = (c_sum >= ANG_FULL) ? ANG_W'(c_sum - ANG_FULL) : ANG_W'(c_sum);
	end

	assign adv1 = !v_s1 || out_ready;
	assign in_ready = adv1;
	assign out_valid = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in_valid;
		end
	end

	// table lookups
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			sc_s1 <= scaled_sine(ang);
			cc_s1 <= scaled_sine(cang);
			mag_s1 <= MAG_W'(mag_clamp);
			rot_s1 <= rotation;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/mwsm_mix.sv =====
`default_nettype none
module mwsm_mix #(
	parameter int FRAC_BITS = 14,
	parameter int DEN_W = 49,
	parameter int RW = 56
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [mwsm_pkg::TRIG_W-1:0] sc_s1,
	input  logic signed [mwsm_pkg::TRIG_W-1:0] cc_s1,
	input  logic signed [mwsm_pkg::MAG_W-1:0] mag_s1,
	input  logic signed [15:0] rot_s1,
	output logic out_valid,
	input  logic out_ready,
	output logic [RW-1:0] num_s5 [mwsm_pkg::NUM_WHEELS],
	output logic [mwsm_pkg::NUM_WHEELS-1:0] neg_s5,
	output logic [DEN_W-1:0] den_s5
);
	import mwsm_pkg::*;

	localparam logic [DEN_W-1:0] DEN_ONE =
		{{(DEN_W-1){1'b0}}, 1'b1} << (FRAC_BITS + TRIG_FRAC);

	logic v_s2, v_s3, v_s4, v_s5;
	logic adv2, adv3, adv4, adv5;
	logic signed [SP_W-2:0] psc_s2, pcc_s2;
	logic signed [15:0] rot_s2;
	logic signed [SP_W-1:0] rot_w;
	logic signed [SP_W-1:0] sp_s3 [NUM_WHEELS];
	logic [ABS_W-1:0] abs_c [NUM_WHEELS];
	logic [ABS_W-1:0] abs_s4 [NUM_WHEELS];
	logic [NUM_WHEELS-1:0] neg_s4;
	logic [ABS_W-1:0] mxa_s4, mxb_s4;
	logic [ABS_W-1:0] mx;
	logic [DEN_W-1:0] den_c;

	// stall chain, last stage first
	assign adv5 = !v_s5 || out_ready;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign in_ready = adv2;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv2) v_s2 <= in_valid;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
		end
	end

	// trig times magnitude
	always_ff @(posedge clk) begin
		if (adv2 && in_valid) begin
			psc_s2 <= sc_s1 * mag_s1;
			pcc_s2 <= cc_s1 * mag_s1;
			rot_s2 <= rot_s1;
		end
	end

	// wheel sums, rotation aligned to the product scale
	assign rot_w = SP_W'($signed({rot_s2, {TRIG_FRAC{1'b0}}}));

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			sp_s3[0] <= SP_W'(psc_s2) + rot_w;
			sp_s3[1] <= SP_W'(pcc_s2) - rot_w;
			sp_s3[2] <= SP_W'(pcc_s2) + rot_w;
			sp_s3[3] <= SP_W'(psc_s2) - rot_w;
		end
	end

	// absolute values and first level of the max tree
	always_comb begin
		for (int l = 0; l < NUM_WHEELS; l++) begin
			abs_c[l] = sp_s3[l][SP_W-1] ? ABS_W'(-sp_s3[l]) : ABS_W'(sp_s3[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv4 && v_s3) begin
			for (int l = 0; l < NUM_WHEELS; l++) begin
				abs_s4[l] <= abs_c[l];
				neg_s4[l] <= sp_s3[l][SP_W-1];
			end
			mxa_s4 <= (abs_c[0] > abs_c[1]) ? abs_c[0] : abs_c[1];
			mxb_s4 <= (abs_c[2] > abs_c[3]) ? abs_c[2] : abs_c[3];
		end
	end

	// final max, divisor and scaled numerators
	always_comb begin
		mx = (mxa_s4 > mxb_s4) ? mxa_s4 : mxb_s4;
		den_c = (DEN_W'(mx) > DEN_ONE) ? DEN_W'(mx) : DEN_ONE;
	end

	always_ff @(posedge clk) begin
		if (adv5 && v_s4) begin
			for (int l = 0; l < NUM_WHEELS; l++) begin
				num_s5[l] <= RW'(abs_s4[l]) * RW'(PCT_SCALE);
			end
			neg_s5 <= neg_s4;
			den_s5 <= den_c;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/mwsm_div.sv =====
`default_nettype none
module mwsm_div #(
	parameter int DEN_W = 49,
	parameter int RW = 56
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [RW-1:0] num_s5 [mwsm_pkg::NUM_WHEELS],
	input  logic [mwsm_pkg::NUM_WHEELS-1:0] neg_s5,
	input  logic [DEN_W-1:0] den_s5,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [mwsm_pkg::PCT_W-1:0] pct [mwsm_pkg::NUM_WHEELS]
);
	import mwsm_pkg::*;

	logic [Q_W-1:0] v_s;
	logic [Q_W-1:0] adv;
	logic [RW-1:0] rem_s [Q_W][NUM_WHEELS];
	logic [Q_W-1:0] quo_s [Q_W][NUM_WHEELS];
	logic [NUM_WHEELS-1:0] neg_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];

	// one quotient bit per stage, most significant first
	for (genvar j = 0; j < Q_W; j++) begin : g_step
		logic [RW-1:0] rem_in [NUM_WHEELS];
		logic [Q_W-1:0] quo_in [NUM_WHEELS];
		logic [NUM_WHEELS-1:0] neg_in;
		logic [DEN_W-1:0] den_in;
		logic v_in;
		logic rdy_next;
		logic [RW-1:0] dsh;

		if (j == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < NUM_WHEELS; l++) begin
					rem_in[l] = num_s5[l];
					quo_in[l] = '0;
				end
				neg_in = neg_s5;
				den_in = den_s5;
				v_in = in_valid;
			end
		end else begin : g_next
			always_comb begin
				for (int l = 0; l < NUM_WHEELS; l++) begin
					rem_in[l] = rem_s[j-1][l];
					quo_in[l] = quo_s[j-1][l];
				end
				neg_in = neg_s[j-1];
				den_in = den_s[j-1];
				v_in = v_s[j-1];
			end
		end

		if (j == Q_W - 1) begin : g_last
			assign rdy_next = out_ready;
		end else begin : g_mid
			assign rdy_next = adv[j+1];
		end

		assign adv[j] = !v_s[j] || rdy_next;
		assign dsh = RW'(den_in) << (Q_W - 1 - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (adv[j]) begin
				v_s[j] <= v_in;
			end
		end

		// compare and subtract the shifted divisor
		always_ff @(posedge clk) begin
			if (adv[j] && v_in) begin
				for (int l = 0; l < NUM_WHEELS; l++) begin
					if (rem_in[l] >= dsh) begin
						rem_s[j][l] <= rem_in[l] - dsh;
						quo_s[j][l] <= quo_in[l] | (Q_W'(1) << (Q_W - 1 - j));
					end else begin
						rem_s[j][l] <= rem_in[l];
						quo_s[j][l] <= quo_in[l];
					end
				end
				neg_s[j] <= neg_in;
				den_s[j] <= den_in;
			end
		end
	end

	assign in_ready = adv[0];
	assign out_valid = v_s[Q_W-1];

	// apply sign, truncation toward zero falls out of the magnitude divide
	always_comb begin
		for (int l = 0; l < NUM_WHEELS; l++) begin
			pct[l] = neg_s[Q_W-1][l] ? -PCT_W'(quo_s[Q_W-1][l])
				: PCT_W'(quo_s[Q_W-1][l]);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/mecanum_wheel_speed_mixer.sv =====
`default_nettype none
// channel | signals                                          | direction
// command | in_valid, in_ready, magnitude, heading_deg, rotation | into block
// speeds  | out_valid, out_ready, speed_front_left/right, speed_back_left/right | out of block
//
// one command per cycle while out_ready holds; stages: table lookup, multiply, wheel sums,
// two levels of the max tree, then seven restoring divide stages (one quotient bit each)
// arst_n clears only the stage valid bits
// each stage holds while the next is full and stalled, so bubbles close up and
// a stall on the speeds side reaches the command side only when every stage is full
module mecanum_wheel_speed_mixer #(
	parameter int FRAC_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [15:0] magnitude,
	input  logic [8:0] heading_deg,
	input  logic signed [15:0] rotation,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [7:0] speed_front_left,
	output logic signed [7:0] speed_front_right,
	output logic signed [7:0] speed_back_left,
	output logic signed [7:0] speed_back_right
);
	import mwsm_pkg::*;

	localparam int DEN_W = (FRAC_BITS + TRIG_FRAC + 1 > ABS_W) ?
		FRAC_BITS + TRIG_FRAC + 1 : ABS_W;
	localparam int RW = DEN_W + Q_W;

	logic t_valid, t_ready;
	logic signed [TRIG_W-1:0] sc_s1, cc_s1;
	logic signed [MAG_W-1:0] mag_s1;
	logic signed [15:0] rot_s1;
	logic m_valid, m_ready;
	logic [RW-1:0] num_s5 [NUM_WHEELS];
	logic [NUM_WHEELS-1:0] neg_s5;
	logic [DEN_W-1:0] den_s5;
	logic signed [PCT_W-1:0] pct [NUM_WHEELS];

	// angle and trig lookup
	mwsm_trig #(.FRAC_BITS(FRAC_BITS)) u_trig (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.magnitude(magnitude), .heading_deg(heading_deg), .rotation(rotation),
		.out_valid(t_valid), .out_ready(t_ready),
		.sc_s1(sc_s1), .cc_s1(cc_s1), .mag_s1(mag_s1), .rot_s1(rot_s1)
	);

	// wheel mixing and normalization divisor
	mwsm_mix #(.FRAC_BITS(FRAC_BITS), .DEN_W(DEN_W), .RW(RW)) u_mix (
		.clk(clk), .arst_n(arst_n),
		.in_valid(t_valid), .in_ready(t_ready),
		.sc_s1(sc_s1), .cc_s1(cc_s1), .mag_s1(mag_s1), .rot_s1(rot_s1),
		.out_valid(m_valid), .out_ready(m_ready),
		.num_s5(num_s5), .neg_s5(neg_s5), .den_s5(den_s5)
	);

	// percent divide
	mwsm_div #(.DEN_W(DEN_W), .RW(RW)) u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(m_valid), .in_ready(m_ready),
		.num_s5(num_s5), .neg_s5(neg_s5), .den_s5(den_s5),
		.out_valid(out_valid), .out_ready(out_ready),
		.pct(pct)
	);

	assign speed_front_left = pct[0];
	assign speed_front_right = pct[1];
	assign speed_back_left = pct[2];
	assign speed_back_right = pct[3];

endmodule
`default_nettype wire

// ===== tb/tb_mecanum_wheel_speed_mixer.sv =====
`default_nettype none
module tb_mecanum_wheel_speed_mixer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS = 14;
	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD = 200;
	localparam int RANDOM_CMDS = 1700;
	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam longint unsigned SQRT2_Q30 = 64'd1518500250;
	localparam longint unsigned HALF_Q30 = 64'd536870912;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	typedef struct packed {
		logic signed [7:0] fl;
		logic signed [7:0] fr;
		logic signed [7:0] bl;
		logic signed [7:0] br;
	} wheel_speeds_t;

	typedef struct packed {
		logic signed [15:0] mag;
		logic [8:0] hdg;
		logic signed [15:0] rot;
		logic typed;
		wheel_speeds_t speeds;
	} drive_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] magnitude = '0;
	logic [8:0] heading_deg = '0;
	logic signed [15:0] rotation = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [7:0] speed_front_left;
	logic signed [7:0] speed_front_right;
	logic signed [7:0] speed_back_left;
	logic signed [7:0] speed_back_right;

	wheel_speeds_t pending_speeds[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	bit hold_req = 1'b0;

	mecanum_wheel_speed_mixer #(.FRAC_BITS(FRAC_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.magnitude(magnitude),
		.heading_deg(heading_deg),
		.rotation(rotation),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.speed_front_left(speed_front_left),
		.speed_front_right(speed_front_right),
		.speed_back_left(speed_back_left),
		.speed_back_right(speed_back_right)
	);

	always #6 clk = ~clk;

	// sine of 0..90 degrees in Q2.30, series expansion
	function automatic longint unsigned series_sine(input int unsigned deg);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint acc;
		x = (64'(deg) * PI_Q30 + 64'd90) / 64'd180;
		x2 = (x * x + HALF_Q30) >> 30;
		term = x;
		acc = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc -= longint'(term);
			end else begin
				acc += longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > longint'(ONE_Q30)) begin
			acc = longint'(ONE_Q30);
		end
		return longint'(acc);
	endfunction

	// sqrt(2) * sin of 0..359 degrees
	function automatic longint root2_sine(input int unsigned ang);
		int unsigned quad;
		int unsigned rem;
		longint unsigned s;
		longint c;
		quad = ang / 90;
		rem = ang % 90;
		s = (quad % 2 == 1) ? series_sine(90 - rem) : series_sine(rem);
		c = longint'((s * SQRT2_Q30 + HALF_Q30) >> 30);
		return (quad >= 2) ? -c : c;
	endfunction

	function automatic logic signed [7:0] to_pct(input longint s, input longint unsigned den);
		longint unsigned a;
		longint unsigned q;
		a = (s < 0) ? longint'(-s) : longint'(s);
		q = (a * 100) / den;
		if (s < 0) begin
			q = -q;
		end
		return q[7:0];
	endfunction

	function automatic wheel_speeds_t mix_wheels(input logic signed [15:0] mag,
			input logic [8:0] hdg, input logic signed [15:0] rot);
		longint one;
		longint m;
		longint r;
		longint sc;
		longint cc;
		longint sp[4];
		longint unsigned den;
		longint unsigned a;
		int unsigned ang;
		wheel_speeds_t w;
		one = longint'(1) << FRAC_BITS;
		m = longint'(mag);
		if (m > one) begin
			m = one;
		end
		if (m < -one) begin
			m = -one;
		end
		r = longint'(rot) <<< 30;
		ang = (int'(hdg) + 45) % 360;
		sc = root2_sine(ang);
		cc = root2_sine((ang + 90) % 360);
		sp[0] = sc * m + r;
		sp[1] = cc * m - r;
		sp[2] = cc * m + r;
		sp[3] = sc * m - r;
		den = longint'(1) << (FRAC_BITS + 30);
		for (int i = 0; i < 4; i++) begin
			a = (sp[i] < 0) ? longint'(-sp[i]) : longint'(sp[i]);
			if (a > den) begin
				den = a;
			end
		end
		w.fl = to_pct(sp[0], den);
		w.fr = to_pct(sp[1], den);
		w.bl = to_pct(sp[2], den);
		w.br = to_pct(sp[3], den);
		return w;
	endfunction

	// offer one command, record its speeds when accepted
	task automatic send_cmd(input logic signed [15:0] mag, input logic [8:0] hdg,
			input logic signed [15:0] rot, input bit typed, input wheel_speeds_t known);
		int gap;
		gap = send_idle ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		magnitude = mag;
		heading_deg = hdg;
		rotation = rot;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_speeds.push_back(typed ? known : mix_wheels(mag, hdg, rot));
		@(negedge clk);
	endtask

	task automatic send_random();
		logic signed [15:0] mag;
		logic [8:0] hdg;
		logic signed [15:0] rot;
		case ($urandom_range(0, 3))
			0: mag = 16'($urandom);
			1: mag = 16'($signed($urandom_range(0, 32768)) - 16384);
			2: mag = ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
			default: mag = 16'($signed($urandom_range(0, 40000)) - 20000);
		endcase
		hdg = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(360, 511))
			: 9'($urandom_range(0, 359));
		case ($urandom_range(0, 5))
			0: rot = 16'($urandom);
			1: rot = '0;
			default: rot = 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
		send_cmd(mag, hdg, rot, 1'b0, '0);
	endtask

	// receiver: random stalls, one long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_req = 1'b0;
			end
			gap = recv_idle ? $urandom_range(0, 3) : 0;
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// compare each delivered speed set with the oldest pending one
	always @(posedge clk) begin
		wheel_speeds_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_speeds.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected speeds %0d %0d %0d %0d", speed_front_left,
						speed_front_right, speed_back_left, speed_back_right);
				end
			end else begin
				want = pending_speeds.pop_front();
				if (want.fl !== speed_front_left || want.fr !== speed_front_right ||
						want.bl !== speed_back_left || want.br !== speed_back_right) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("speed mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
							want.fl, want.fr, want.bl, want.br, speed_front_left,
							speed_front_right, speed_back_left, speed_back_right);
					end
				end
			end
		end
	end

	// watchdog on cycles with no request moving either way
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_mecanum_wheel_speed_mixer failed");
			$finish;
		end
	end

	initial begin
		drive_row_t rows[];
		rows = '{
			'{16'sd0, 9'd0, 16'sd0, 1'b1, '{8'sd0, 8'sd0, 8'sd0, 8'sd0}},
			'{16'sd0, 9'd0, 16'sd16384, 1'b1, '{8'sd100, -8'sd100, 8'sd100, -8'sd100}},
			'{16'sd0, 9'd90, -16'sd16384, 1'b1, '{-8'sd100, 8'sd100, -8'sd100, 8'sd100}},
			'{16'sd16384, 9'd45, 16'sd0, 1'b1, '{8'sd100, 8'sd0, 8'sd0, 8'sd100}},
			'{16'sd32767, 9'd0, 16'sd0, 1'b0, '0},
			'{-16'sd32768, 9'd0, 16'sd0, 1'b0, '0},
			'{16'sd16385, 9'd200, 16'sd0, 1'b0, '0},
			'{16'sd16384, 9'd90, 16'sd0, 1'b0, '0},
			'{16'sd16384, 9'd135, 16'sd0, 1'b0, '0},
			'{16'sd16384, 9'd180, 16'sd0, 1'b0, '0},
			'{16'sd16384, 9'd270, 16'sd0, 1'b0, '0},
			'{16'sd16384, 9'd315, 16'sd0, 1'b0, '0},
			'{16'sd16384, 9'd359, 16'sd0, 1'b0, '0},
			// headings past a full turn wrap around
			'{16'sd16384, 9'd360, 16'sd0, 1'b0, '0},
			'{16'sd16384, 9'd405, 16'sd4096, 1'b0, '0},
			'{-16'sd8000, 9'd511, -16'sd3000, 1'b0, '0},
			// rotation beyond full scale still normalizes
			'{16'sd16384, 9'd0, 16'sd32767, 1'b0, '0},
			'{16'sd16384, 9'd30, -16'sd32768, 1'b0, '0},
			'{16'sd1, 9'd10, -16'sd1, 1'b0, '0},
			'{-16'sd16384, 9'd315, 16'sd8000, 1'b0, '0},
			'{16'sd12000, 9'd170, 16'sd9000, 1'b0, '0}
		};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			send_cmd(rows[i].mag, rows[i].hdg, rows[i].rot, rows[i].typed, rows[i].speeds);
		end

		// random commands in phases: stalls, long hold-off, drain, back-to-back
		for (int k = 0; k < RANDOM_CMDS; k++) begin
			if (k == 400) begin
				send_idle = 1'b0;
				hold_req = 1'b1;
			end
			if (k == 460) begin
				in_valid = 1'b0;
				while (pending_speeds.size() != 0) @(negedge clk);
				send_idle = 1'b1;
			end
			if (k == 800) begin
				send_idle = 1'b0;
				recv_idle = 1'b0;
			end
			if (k == 1100) begin
				send_idle = 1'b1;
				recv_idle = 1'b1;
			end
			if (k == 1400) begin
				recv_idle = 1'b0;
			end
			send_random();
		end
		in_valid = 1'b0;

		while (pending_speeds.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_mecanum_wheel_speed_mixer passed");
		end else begin
			$display("tb_mecanum_wheel_speed_mixer failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/mwsm_pkg.sv
rtl/core/mwsm_trig.sv
rtl/core/mwsm_mix.sv
rtl/core/mwsm_div.sv
rtl/core/mecanum_wheel_speed_mixer.sv
tb/tb_mecanum_wheel_speed_mixer.sv
